FILE: src/aips_pkg.sv
// ----------------------------------------------------------------------------
// aips_pkg: shared types and constants for the converter poll sequencer
// Holds transfer status codes, register indexes, phase encoding and the
// bundles passed between the configuration, core and top-level modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aips_pkg;

  localparam int unsigned TickW   = 10;
  localparam int unsigned ToutW   = 8;
  localparam int unsigned RetryW  = 4;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 10;

  localparam logic [TickW-1:0]   TickMax  = '1;
  localparam logic [RetryW-1:0]  RetryMax = '1;

  localparam logic [TickW-1:0]   ConvTicksRst  = TickW'(143);
  localparam logic [ToutW-1:0]   TimeoutRst    = ToutW'(10);
  localparam logic [RetryW-1:0]  RetryLimitRst = RetryW'(5);
  localparam logic [TickW-1:0]   BackoffRst    = TickW'(10);

  typedef enum logic [1:0] {
    BUS_PENDING  = 2'd0,
    BUS_COMPLETE = 2'd1,
    BUS_NACK     = 2'd2,
    BUS_ERROR    = 2'd3
  } bus_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CONV_TICKS   = 2'd0,
    REG_TIMEOUT      = 2'd1,
    REG_RETRY_LIMIT  = 2'd2,
    REG_NACK_BACKOFF = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    PH_CONVERT = 1'b0,
    PH_STATUS  = 1'b1
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0]  conv_ticks;
    logic [ToutW-1:0]  timeout_ticks;
    logic [RetryW-1:0] retry_limit;
    logic [TickW-1:0]  backoff_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] byte_high;
    logic [7:0] byte_mid;
    logic [7:0] byte_low;
  } tick_item_t;

  typedef struct packed {
    logic               read_request;
    logic               sample_valid;
    logic [SampleW-1:0] sample_value;
  } result_t;

endpackage

`default_nettype wire

FILE: src/aips_cfg.sv
// ----------------------------------------------------------------------------
// aips_cfg: configuration register file
// Four timing/limit registers written through a valid/ready port.
// ----------------------------------------------------------------------------
`default_nettype none

module aips_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [aips_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [aips_pkg::CfgDatW-1:0]  cfg_data_i,
  output aips_pkg::cfg_t                     cfg_o
);
  import aips_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conv_ticks    <= ConvTicksRst;
      cfg_q.timeout_ticks <= TimeoutRst;
      cfg_q.retry_limit   <= RetryLimitRst;
      cfg_q.backoff_ticks <= BackoffRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CONV_TICKS:   cfg_q.conv_ticks    <= cfg_data_i[TickW-1:0];
        REG_TIMEOUT:      cfg_q.timeout_ticks <= cfg_data_i[ToutW-1:0];
        REG_RETRY_LIMIT:  cfg_q.retry_limit   <= cfg_data_i[RetryW-1:0];
        REG_NACK_BACKOFF: cfg_q.backoff_ticks <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/aips_core.sv
// ----------------------------------------------------------------------------
// aips_core: poll sequencer state and per-tick update
// Holds phase, tick and retry counters and the last sample; computes the
// result for one tick item and commits the new state when step_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module aips_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  aips_pkg::tick_item_t    item_i,
  input  aips_pkg::cfg_t          cfg_i,
  output aips_pkg::result_t       result_o
);
  import aips_pkg::*;

  phase_e              phase_q, phase_d;
  logic [TickW-1:0]    tick_q, tick_d;
  logic [RetryW-1:0]   retry_q, retry_d;
  logic [SampleW-1:0]  held_q, held_d;
  logic                held_vld_q, held_vld_d;

  logic [TickW-1:0]    tick_inc;
  logic [RetryW-1:0]   retry_inc;
  logic [TickW-1:0]    nack_tick;
  logic                conv_done;
  logic                timed_out;
  logic                retry_ok;
  bus_status_e         status;
  logic                read_req;
  logic                smp_vld;
  logic [SampleW-1:0]  smp_val;

  assign status    = bus_status_e'(item_i.status);
  assign tick_inc  = (tick_q == TickMax) ? tick_q : tick_q + TickW'(1);
  assign retry_inc = (retry_q == RetryMax) ? retry_q : retry_q + RetryW'(1);
  assign nack_tick = (cfg_i.conv_ticks > cfg_i.backoff_ticks) ?
                     cfg_i.conv_ticks - cfg_i.backoff_ticks : '0;
  assign conv_done = tick_inc >= cfg_i.conv_ticks;
  assign timed_out = tick_inc >= {{(TickW-ToutW){1'b0}}, cfg_i.timeout_ticks};
  assign retry_ok  = retry_inc < cfg_i.retry_limit;

  // Phase transitions
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_CONVERT: begin
        if (conv_done) phase_d = PH_STATUS;
      end
      PH_STATUS: begin
        case (status)
          BUS_PENDING:  if (timed_out) phase_d = PH_CONVERT;
          BUS_COMPLETE: phase_d = PH_CONVERT;
          BUS_NACK:     phase_d = PH_CONVERT;
          BUS_ERROR:    if (!retry_ok) phase_d = PH_CONVERT;
          default:      phase_d = phase_q;
        endcase
      end
      default: phase_d = PH_CONVERT;
    endcase
  end

  // Counters, held sample and read request
  always_comb begin
    tick_d     = tick_q;
    retry_d    = retry_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    read_req   = 1'b0;
    case (phase_q)
      PH_CONVERT: begin
        if (conv_done) begin
          tick_d   = '0;
          retry_d  = '0;
          read_req = 1'b1;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_STATUS: begin
        case (status)
          BUS_PENDING: begin
            if (timed_out) begin
              tick_d     = '0;
              held_vld_d = 1'b0;
            end else begin
              tick_d = tick_inc;
            end
          end
          BUS_COMPLETE: begin
            held_d     = {item_i.byte_high[5:0], item_i.byte_mid, item_i.byte_low[7:6]};
            held_vld_d = 1'b1;
            tick_d     = '0;
          end
          BUS_NACK: begin
            tick_d = nack_tick;
          end
          BUS_ERROR: begin
            retry_d = retry_inc;
            tick_d  = '0;
            if (retry_ok) begin
              read_req = 1'b1;
            end else begin
              held_vld_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Sample is only shown while waiting for the next conversion
  assign smp_vld  = (phase_d == PH_CONVERT) && held_vld_d;
  assign smp_val  = smp_vld ? held_d : '0;
  assign result_o = {read_req, smp_vld, smp_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CONVERT;
      tick_q     <= '0;
      retry_q    <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      retry_q    <= retry_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/adc_i2c_poll_sequencer.sv
// ----------------------------------------------------------------------------
// adc_i2c_poll_sequencer: tick-driven poll sequencer for a converter on I2C
// Each input item is one millisecond tick carrying the bus transfer status
// and three response bytes. Every tick produces exactly one result: a read
// request strobe and the last unpacked 16-bit sample with its valid flag.
//
// Input channel: in_valid_i / in_stall_o with bus_status_i, byte_*_i.
// Output channel: out_valid_o / out_stall_i with read_request_o,
// sample_valid_o, sample_value_o. A transfer happens when valid is high and
// stall is low.
// Configuration: cfg_valid_i / cfg_ready_o, cfg_index_i selects conversion
// ticks, timeout ticks, retry limit or NACK backoff; cfg_ready_o is always
// high. Write only while no tick is in flight.
//
// Input transfer to result passes through the input register and then the
// result register. One tick is taken every cycle while the receiver does not
// stall; the sequencer state update between the two registers is the only loop.
// Reset clears all state and loads register defaults (143, 10, 5, 10).
// When the receiver stalls, the result register holds and the input
// register fills, then in_stall_o rises in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_i2c_poll_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    bus_status_i,
  input  wire logic [7:0]                    byte_high_i,
  input  wire logic [7:0]                    byte_mid_i,
  input  wire logic [7:0]                    byte_low_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               read_request_o,
  output logic                               sample_valid_o,
  output logic [aips_pkg::SampleW-1:0]       sample_value_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [aips_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [aips_pkg::CfgDatW-1:0]  cfg_data_i
);
  import aips_pkg::*;

  cfg_t        cfg;
  tick_item_t  item_q;
  logic        item_vld_q;
  result_t     core_res;
  result_t     res_q;
  logic        res_vld_q;
  logic        advance;
  logic        step;
  logic        in_xfer;

  assign advance    = !res_vld_q || !out_stall_i;
  assign step       = item_vld_q && advance;
  assign in_stall_o = item_vld_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  aips_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  aips_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_xfer) begin
      item_vld_q <= 1'b1;
    end else if (step) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.status    <= bus_status_i;
      item_q.byte_high <= byte_high_i;
      item_q.byte_mid  <= byte_mid_i;
      item_q.byte_low  <= byte_low_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign read_request_o = res_q.read_request;
  assign sample_valid_o = res_q.sample_valid;
  assign sample_value_o = res_q.sample_value;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: converter poll sequencer, tick stream against a local predictor
// Drives tick items with random sender gaps and receiver stalls, predicts
// the read request and held sample of every tick, and checks each result
// transfer in order. Registers are reloaded between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aips_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           bus_status_i = BUS_PENDING;
  logic [7:0]           byte_high_i  = 8'h00;
  logic [7:0]           byte_mid_i   = 8'h00;
  logic [7:0]           byte_low_i   = 8'h00;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic                 read_request_o;
  logic                 sample_valid_o;
  logic [SampleW-1:0]   sample_value_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i  = REG_CONV_TICKS;
  logic [CfgDatW-1:0]   cfg_data_i   = '0;

  adc_i2c_poll_sequencer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .bus_status_i   (bus_status_i),
    .byte_high_i    (byte_high_i),
    .byte_mid_i     (byte_mid_i),
    .byte_low_i     (byte_low_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_request_o (read_request_o),
    .sample_valid_o (sample_valid_o),
    .sample_value_o (sample_value_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Sequencer copy: registers and state as the block should hold them.
  logic [TickW-1:0]   conv_ticks    = ConvTicksRst;
  logic [ToutW-1:0]   timeout_ticks = TimeoutRst;
  logic [RetryW-1:0]  retry_limit   = RetryLimitRst;
  logic [TickW-1:0]   backoff_ticks = BackoffRst;
  phase_e             seq_phase     = PH_CONVERT;
  logic [TickW-1:0]   tick_count    = '0;
  logic [RetryW-1:0]  retry_count   = '0;
  logic [SampleW-1:0] held_sample   = '0;
  logic               held_valid    = 1'b0;
  logic               last_request  = 1'b0;

  result_t     poll_results[$];
  result_t     due_result;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(string what);
    if (mismatches < 100) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (poll_results.size() == 0) begin
        report_mismatch("result transfer with no tick outstanding");
      end else begin
        due_result = poll_results.pop_front();
        if (read_request_o !== due_result.read_request)
          report_mismatch($sformatf("read_request %b, want %b",
                                    read_request_o, due_result.read_request));
        if (sample_valid_o !== due_result.sample_valid)
          report_mismatch($sformatf("sample_valid %b, want %b",
                                    sample_valid_o, due_result.sample_valid));
        if (sample_value_o !== due_result.sample_value)
          report_mismatch($sformatf("sample_value %h, want %h",
                                    sample_value_o, due_result.sample_value));
      end
    end
  end

  task automatic abandon_read();
    held_valid = 1'b0;
    tick_count = '0;
    seq_phase  = PH_CONVERT;
  endtask

  task automatic advance_sequencer(bus_status_e st, logic [7:0] bh, logic [7:0] bm,
                                   logic [7:0] bl);
    result_t r;
    r = '0;
    if (seq_phase == PH_CONVERT) begin
      if (tick_count != TickMax) tick_count = tick_count + 1'b1;
      if (tick_count >= conv_ticks) begin
        tick_count     = '0;
        retry_count    = '0;
        r.read_request = 1'b1;
        seq_phase      = PH_STATUS;
      end
    end else begin
      case (st)
        BUS_PENDING: begin
          if (tick_count != TickMax) tick_count = tick_count + 1'b1;
          if (tick_count >= timeout_ticks) abandon_read();
        end
        BUS_COMPLETE: begin
          held_sample = {bh[5:0], bm, bl[7:6]};
          held_valid  = 1'b1;
          tick_count  = '0;
          seq_phase   = PH_CONVERT;
        end
        BUS_NACK: begin
          tick_count = (conv_ticks > backoff_ticks) ? conv_ticks - backoff_ticks : '0;
          seq_phase  = PH_CONVERT;
        end
        default: begin
          if (retry_count != RetryMax) retry_count = retry_count + 1'b1;
          if (retry_count < retry_limit) begin
            tick_count     = '0;
            r.read_request = 1'b1;
          end else begin
            abandon_read();
          end
        end
      endcase
    end
    r.sample_valid = (seq_phase == PH_CONVERT) && held_valid;
    r.sample_value = r.sample_valid ? held_sample : '0;
    last_request   = r.read_request;
    poll_results.push_back(r);
  endtask

  function automatic bus_status_e any_status();
    return bus_status_e'($urandom_range(0, 3));
  endfunction

  // Entered and left at a falling edge; valid stays high for a following tick.
  task automatic send_tick(bus_status_e st, logic [7:0] bh, logic [7:0] bm, logic [7:0] bl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    bus_status_i <= st;
    byte_high_i  <= bh;
    byte_mid_i   <= bm;
    byte_low_i   <= bl;
    do @(posedge clk_i); while (in_stall_o);
    advance_sequencer(st, bh, bm, bl);
    @(negedge clk_i);
  endtask

  task automatic send_any_tick(bus_status_e st);
    send_tick(st, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (poll_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CONV_TICKS:  conv_ticks    = data[TickW-1:0];
      REG_TIMEOUT:     timeout_ticks = data[ToutW-1:0];
      REG_RETRY_LIMIT: retry_limit   = data[RetryW-1:0];
      default:         backoff_ticks = data[TickW-1:0];
    endcase
    @(negedge clk_i);
  endtask

  // Drain all ticks in flight, let the pipeline settle, then reload.
  task automatic load_registers(logic [CfgDatW-1:0] conv, logic [CfgDatW-1:0] tout,
                                logic [CfgDatW-1:0] retry, logic [CfgDatW-1:0] backoff);
    in_valid_i <= 1'b0;
    while (poll_results.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
    write_register(REG_CONV_TICKS, conv);
    write_register(REG_TIMEOUT, tout);
    write_register(REG_RETRY_LIMIT, retry);
    write_register(REG_NACK_BACKOFF, backoff);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed polls: noise while converting, weighted status after a read.
  task automatic run_traffic(int unsigned count);
    int unsigned pick;
    bus_status_e st;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 59) == 0) hold_until_drained();
      if (seq_phase == PH_STATUS) begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      st = BUS_PENDING;
        else if (pick < 60) st = BUS_COMPLETE;
        else if (pick < 75) st = BUS_NACK;
        else                st = BUS_ERROR;
      end else begin
        st = any_status();
      end
      send_any_tick(st);
    end
  endtask

  task automatic test_reset_defaults();
    run_traffic(200);
  endtask

  task automatic test_directed();
    load_registers(10'd1, 10'd2, 10'd2, 10'd0);
    send_tick(BUS_PENDING, 8'hFF, 8'hFF, 8'hFF);   // bytes ignored while converting
    send_tick(BUS_COMPLETE, 8'hFF, 8'hFF, 8'hFF);
    send_tick(BUS_ERROR, 8'h00, 8'h00, 8'h00);
    send_tick(BUS_COMPLETE, 8'hC0, 8'h00, 8'h3F);  // masked bits only
    send_tick(BUS_PENDING, 8'h00, 8'h00, 8'h00);
    send_tick(BUS_COMPLETE, 8'h2A, 8'h55, 8'h80);
    send_tick(BUS_PENDING, 8'h00, 8'h00, 8'h00);
    send_tick(BUS_NACK, 8'h00, 8'h00, 8'h00);
    send_tick(BUS_PENDING, 8'h00, 8'h00, 8'h00);
    send_tick(BUS_ERROR, 8'h00, 8'h00, 8'h00);
    send_tick(BUS_ERROR, 8'h00, 8'h00, 8'h00);     // retry limit reached
    send_tick(BUS_PENDING, 8'h00, 8'h00, 8'h00);
    send_tick(BUS_PENDING, 8'h00, 8'h00, 8'h00);
    send_tick(BUS_PENDING, 8'h00, 8'h00, 8'h00);   // timeout
    send_tick(BUS_PENDING, 8'h00, 8'h00, 8'h00);
    send_any_tick(BUS_COMPLETE);
  endtask

  task automatic test_zero_registers();
    load_registers(10'd0, 10'd0, 10'd0, 10'd1023);
    send_any_tick(BUS_PENDING);
    send_any_tick(BUS_PENDING);    // times out on the first pending tick
    send_any_tick(BUS_PENDING);
    send_any_tick(BUS_ERROR);      // gives up on the first error
    send_any_tick(BUS_PENDING);
    send_any_tick(BUS_NACK);       // backoff larger than conversion wait
    send_any_tick(BUS_PENDING);
    send_any_tick(BUS_COMPLETE);
    send_any_tick(BUS_PENDING);
  endtask

  task automatic test_lowered_limit();
    load_registers(10'd1023, 10'd10, 10'd5, 10'd10);
    repeat (40) send_any_tick(any_status());
    // count already past the new wait: read goes out on the next tick
    load_registers(10'd20, 10'd10, 10'd5, 10'd10);
    send_any_tick(BUS_PENDING);
    send_any_tick(BUS_COMPLETE);
  endtask

  task automatic test_extreme_registers();
    int unsigned guard;
    // oversized timeout and retry writes keep only their low bits
    load_registers(10'd1, 10'd1023, 10'd1023, 10'd1023);
    guard = 0;
    do begin
      send_any_tick(any_status());
      guard++;
    end while (!last_request && guard < 1100);
    repeat (255) send_any_tick(BUS_PENDING);
    load_registers(10'd1, 10'd255, 10'd15, 10'd1023);
    send_any_tick(BUS_PENDING);
    repeat (15) send_any_tick(BUS_ERROR);
    send_any_tick(BUS_PENDING);
    send_any_tick(BUS_NACK);
    send_any_tick(BUS_PENDING);
    send_any_tick(BUS_COMPLETE);
    send_any_tick(BUS_PENDING);
  endtask

  task automatic test_random_traffic();
    logic [CfgDatW-1:0] conv, tout, retry, backoff;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 87 : 0;
      stall_pct     = (mode == 0) ? 87 : (mode == 1) ? 16 : 0;
      repeat (6) begin
        conv    = ($urandom_range(0, 9) == 0) ? CfgDatW'($urandom_range(0, 1023))
                                              : CfgDatW'($urandom_range(0, 6));
        tout    = ($urandom_range(0, 9) == 0) ? CfgDatW'($urandom_range(0, 1023))
                                              : CfgDatW'($urandom_range(0, 6));
        retry   = ($urandom_range(0, 9) == 0) ? CfgDatW'($urandom_range(0, 1023))
                                              : CfgDatW'($urandom_range(0, 5));
        backoff = ($urandom_range(0, 3) == 0) ? CfgDatW'($urandom_range(0, 1023))
                                              : CfgDatW'($urandom_range(0, 8));
        load_registers(conv, tout, retry, backoff);
        run_traffic(40);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 16;
    stall_pct     = 87;
    test_reset_defaults();
    test_directed();
    test_zero_registers();
    test_lowered_limit();
    send_idle_pct = 0;
    stall_pct     = 0;
    test_extreme_registers();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (poll_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && poll_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
